[rtl/bfdw_pkg.sv]
// ----------------------------------------------------------------------------
// bfdw_pkg
// Shared widths, register indexes, reset values and stream item layouts of
// the body-frame drag wrench block.
// ----------------------------------------------------------------------------
`default_nettype none

package bfdw_pkg;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int IN_W      = 256;
  localparam int OUT_W     = 192;
  localparam int STAGES    = 12;
  localparam int MAT_W     = 22;

  localparam logic [CFG_IDX_W-1:0] CFG_LIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG    = 3'd6;

  localparam logic [CFG_W-1:0] LIN_RST  = 24'd19661;
  localparam logic [CFG_W-1:0] QUAD_RST = 24'd1311;
  localparam logic [CFG_W-1:0] ANG_RST  = 24'd655;

  // last field in the lowest bits
  typedef struct packed {
    logic signed [31:0] omega_z;
    logic signed [31:0] omega_y;
    logic signed [31:0] omega_x;
    logic signed [31:0] vel_z;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_w;
  } item_t;

  typedef struct packed {
    logic signed [31:0] torque_z;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_x;
    logic signed [31:0] force_z;
    logic signed [31:0] force_y;
    logic signed [31:0] force_x;
  } res_t;

endpackage

`default_nettype wire

[rtl/body_frame_drag_wrench.sv]
// ----------------------------------------------------------------------------
// body_frame_drag_wrench
// Linear plus quadratic body-axis drag force and angular damping torque
// for one link orientation and velocity pair per request.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  quat, vel, omega
//   m_axis    out  m_axis_tvalid / m_axis_tready  force, torque
//   cfg       in   cfg_we_i                       cfg_idx_i, cfg_wdata_i
//
// Twelve register stages, one request per cycle while the output side does
// not stall. The deepest stage is one 24x32 or 22x32 multiply, or one wide
// add. Each stage holds a valid bit and advances when it is empty or the
// next stage advances, so bubbles close up under a stall. Reset clears the
// valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module body_frame_drag_wrench (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bfdw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bfdw_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // quat_w, quat_x, quat_y, quat_z, vel_x, vel_y, vel_z,
  // omega_x, omega_y, omega_z
  input  logic [bfdw_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // force_x, force_y, force_z, torque_x, torque_y, torque_z
  output logic [bfdw_pkg::OUT_W-1:0]     m_axis_tdata
);

  localparam int NS = bfdw_pkg::STAGES;
  localparam int MW = bfdw_pkg::MAT_W;
  localparam logic signed [41:0] SAT_HI = 42'sd2147483647;
  localparam logic signed [41:0] SAT_LO = -42'sd2147483648;

  typedef struct packed {
    logic signed [31:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  } qprod_t;

  typedef logic [2:0][2:0][MW-1:0] mat_t;
  typedef logic [2:0][31:0]        vec32_t;

  function automatic logic [MW-1:0] rnd12(input logic signed [33:0] s);
    logic signed [33:0] t;
    t = s + 34'sd2048;
    return t[33:12];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [41:0] x);
    logic [31:0] r;
    if (x > SAT_HI) begin
      r = 32'h7FFF_FFFF;
    end else if (x < SAT_LO) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // configuration
  logic [2:0][bfdw_pkg::CFG_W-1:0] lin_q, quad_q;
  logic [bfdw_pkg::CFG_W-1:0]      ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_q  <= {3{bfdw_pkg::LIN_RST}};
      quad_q <= {3{bfdw_pkg::QUAD_RST}};
      ang_q  <= bfdw_pkg::ANG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bfdw_pkg::CFG_LIN_X:  lin_q[0]  <= cfg_wdata_i;
        bfdw_pkg::CFG_LIN_Y:  lin_q[1]  <= cfg_wdata_i;
        bfdw_pkg::CFG_LIN_Z:  lin_q[2]  <= cfg_wdata_i;
        bfdw_pkg::CFG_QUAD_X: quad_q[0] <= cfg_wdata_i;
        bfdw_pkg::CFG_QUAD_Y: quad_q[1] <= cfg_wdata_i;
        bfdw_pkg::CFG_QUAD_Z: quad_q[2] <= cfg_wdata_i;
        bfdw_pkg::CFG_ANG:    ang_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage control
  logic [NS:1] vld_q, vld_d, en;

  always_comb begin
    en[NS] = !vld_q[NS] || m_axis_tready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[1] = en[1] ? s_axis_tvalid : vld_q[1];
    for (int k = 2; k <= NS; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = vld_q[NS];

  // carried payload
  mat_t              mat_q  [2:10];
  vec32_t            tq_q   [2:11];
  vec32_t            vel_q  [1:2];
  logic [2:0][36:0]  mag_q  [5:7];
  logic [2:0]        neg_q  [5:9];
  logic [2:0][60:0]  linp_q [7:9];
  logic [2:0]        big_q  [7:9];

  // stage 1: quaternion products, torque products
  bfdw_pkg::item_t  in_item;
  qprod_t           qp_d, s1_qp_q;
  logic [2:0][56:0] tqp_d, s1_tqp_q;

  assign in_item = bfdw_pkg::item_t'(s_axis_tdata);

  always_comb begin
    qp_d.ww = in_item.quat_w * in_item.quat_w;
    qp_d.xx = in_item.quat_x * in_item.quat_x;
    qp_d.yy = in_item.quat_y * in_item.quat_y;
    qp_d.zz = in_item.quat_z * in_item.quat_z;
    qp_d.xy = in_item.quat_x * in_item.quat_y;
    qp_d.wz = in_item.quat_w * in_item.quat_z;
    qp_d.xz = in_item.quat_x * in_item.quat_z;
    qp_d.wy = in_item.quat_w * in_item.quat_y;
    qp_d.yz = in_item.quat_y * in_item.quat_z;
    qp_d.wx = in_item.quat_w * in_item.quat_x;
    tqp_d[0] = $signed({1'b0, ang_q}) * in_item.omega_x;
    tqp_d[1] = $signed({1'b0, ang_q}) * in_item.omega_y;
    tqp_d[2] = $signed({1'b0, ang_q}) * in_item.omega_z;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_qp_q  <= qp_d;
      s1_tqp_q <= tqp_d;
      vel_q[1] <= {in_item.vel_z, in_item.vel_y, in_item.vel_x};
    end
  end

  // stage 2: rotation matrix in Q.16, torque rounding
  logic signed [33:0] sm [3][3];
  logic signed [57:0] tn [3];
  logic [41:0]        tr [3];
  mat_t               mat_d;
  vec32_t             tq_d;

  always_comb begin
    sm[0][0] = s1_qp_q.ww + s1_qp_q.xx - s1_qp_q.yy - s1_qp_q.zz;
    sm[0][1] = (s1_qp_q.xy - s1_qp_q.wz) <<< 1;
    sm[0][2] = (s1_qp_q.xz + s1_qp_q.wy) <<< 1;
    sm[1][0] = (s1_qp_q.xy + s1_qp_q.wz) <<< 1;
    sm[1][1] = s1_qp_q.ww - s1_qp_q.xx + s1_qp_q.yy - s1_qp_q.zz;
    sm[1][2] = (s1_qp_q.yz - s1_qp_q.wx) <<< 1;
    sm[2][0] = (s1_qp_q.xz - s1_qp_q.wy) <<< 1;
    sm[2][1] = (s1_qp_q.yz + s1_qp_q.wx) <<< 1;
    sm[2][2] = s1_qp_q.ww - s1_qp_q.xx - s1_qp_q.yy + s1_qp_q.zz;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mat_d[i][j] = rnd12(sm[i][j]);
      end
      tn[i]   = -$signed(s1_tqp_q[i]);
      tn[i]   = tn[i] + 58'sd32768;
      tr[i]   = tn[i][57:16];
      tq_d[i] = sat32($signed(tr[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      vel_q[2] <= vel_q[1];
    end
  end

  // stage 3: R^T v products
  logic [2:0][2:0][53:0] pv_d, s3_pv_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pv_d[i][j] = $signed(mat_q[2][j][i]) * $signed(vel_q[2][j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_pv_q <= pv_d;
    end
  end

  // stage 4: body velocity
  logic signed [55:0] vacc [3];
  logic [2:0][39:0]   vb_d, s4_vb_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vacc[i] = $signed(s3_pv_q[i][0]) + $signed(s3_pv_q[i][1])
              + $signed(s3_pv_q[i][2]) + 56'sd32768;
      vb_d[i] = vacc[i][55:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_vb_q <= vb_d;
    end
  end

  // stage 5: magnitude and sign
  logic [39:0]      mag40 [3];
  logic [2:0][36:0] mag_d;
  logic [2:0]       neg_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = s4_vb_q[i][39];
      mag40[i] = neg_d[i] ? (40'd0 - s4_vb_q[i]) : s4_vb_q[i];
      mag_d[i] = mag40[i][36:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      mag_q[5] <= mag_d;
      neg_q[5] <= neg_d;
    end
  end

  // stage 6: coefficient partial products
  logic [2:0][42:0] ll_d, ql_d, s6_ll_q, s6_ql_q;
  logic [2:0][41:0] lh_d, qh_d, s6_lh_q, s6_qh_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ll_d[i] = lin_q[i] * mag_q[5][i][18:0];
      lh_d[i] = lin_q[i] * mag_q[5][i][36:19];
      ql_d[i] = quad_q[i] * mag_q[5][i][18:0];
      qh_d[i] = quad_q[i] * mag_q[5][i][36:19];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_ll_q  <= ll_d;
      s6_lh_q  <= lh_d;
      s6_ql_q  <= ql_d;
      s6_qh_q  <= qh_d;
      mag_q[6] <= mag_q[5];
      neg_q[6] <= neg_q[5];
    end
  end

  // stage 7: linear term, rounded quadratic factor
  logic [61:0]      qsum [3];
  logic [45:0]      afull [3];
  logic [2:0][60:0] linp_d;
  logic [2:0][32:0] a_d, s7_a_q;
  logic [2:0]       big_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      linp_d[i] = (61'(s6_lh_q[i]) << 19) + 61'(s6_ll_q[i]);
      qsum[i]   = (62'(s6_qh_q[i]) << 19) + 62'(s6_ql_q[i]) + 62'd32768;
      afull[i]  = qsum[i][61:16];
      // a factor this large saturates the force on its own
      big_d[i]  = |afull[i][45:33];
      a_d[i]    = afull[i][32:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      linp_q[7] <= linp_d;
      s7_a_q    <= a_d;
      big_q[7]  <= big_d;
      mag_q[7]  <= mag_q[6];
      neg_q[7]  <= neg_q[6];
    end
  end

  // stage 8: quadratic partial products
  logic [2:0][37:0] pll_d, s8_pll_q;
  logic [2:0][36:0] plh_d, s8_plh_q;
  logic [2:0][32:0] phl_d, s8_phl_q;
  logic [2:0][31:0] phh_d, s8_phh_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pll_d[i] = s7_a_q[i][18:0]  * mag_q[7][i][18:0];
      plh_d[i] = s7_a_q[i][18:0]  * mag_q[7][i][36:19];
      phl_d[i] = s7_a_q[i][32:19] * mag_q[7][i][18:0];
      phh_d[i] = s7_a_q[i][32:19] * mag_q[7][i][36:19];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s8_pll_q  <= pll_d;
      s8_plh_q  <= plh_d;
      s8_phl_q  <= phl_d;
      s8_phh_q  <= phh_d;
      linp_q[8] <= linp_q[7];
      big_q[8]  <= big_q[7];
      neg_q[8]  <= neg_q[7];
    end
  end

  // stage 9: quadratic term
  logic [37:0]      pmid [3];
  logic [2:0][69:0] am_d, s9_am_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pmid[i] = 38'(s8_plh_q[i]) + 38'(s8_phl_q[i]);
      am_d[i] = 70'(s8_pll_q[i]) + (70'(pmid[i]) << 19) + (70'(s8_phh_q[i]) << 38);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      s9_am_q   <= am_d;
      linp_q[9] <= linp_q[8];
      big_q[9]  <= big_q[8];
      neg_q[9]  <= neg_q[8];
    end
  end

  // stage 10: drag magnitude, sign and saturation
  logic [70:0]   tot [3];
  logic [54:0]   rmag [3];
  vec32_t        fb_d, s10_fb_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i]  = 71'(linp_q[9][i]) + 71'(s9_am_q[i]) + 71'd32768;
      rmag[i] = tot[i][70:16];
      if (neg_q[9][i]) begin
        fb_d[i] = (big_q[9][i] || rmag[i] > 55'd2147483647) ?
                  32'h7FFF_FFFF : rmag[i][31:0];
      end else begin
        fb_d[i] = (big_q[9][i] || rmag[i] > 55'd2147483648) ?
                  32'h8000_0000 : 32'd0 - rmag[i][31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      s10_fb_q <= fb_d;
    end
  end

  // stage 11: R fb products
  logic [2:0][2:0][53:0] pf_d, s11_pf_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pf_d[i][j] = $signed(mat_q[10][i][j]) * $signed(s10_fb_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[11]) begin
      s11_pf_q <= pf_d;
    end
  end

  // stage 12: world force, output register
  logic signed [55:0] facc [3];
  logic [39:0]        fr [3];
  vec32_t             fw;
  bfdw_pkg::res_t     out_d, out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      facc[i] = $signed(s11_pf_q[i][0]) + $signed(s11_pf_q[i][1])
              + $signed(s11_pf_q[i][2]) + 56'sd32768;
      fr[i]   = facc[i][55:16];
      fw[i]   = sat32(42'($signed(fr[i])));
    end
    out_d.force_x  = fw[0];
    out_d.force_y  = fw[1];
    out_d.force_z  = fw[2];
    out_d.torque_x = tq_q[11][0];
    out_d.torque_y = tq_q[11][1];
    out_d.torque_z = tq_q[11][2];
  end

  always_ff @(posedge clk_i) begin
    if (en[12]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tdata = out_q;

  // shift lines for matrix and torque
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      mat_q[2] <= mat_d;
      tq_q[2]  <= tq_d;
    end
    for (int k = 3; k <= 10; k++) begin
      if (en[k]) begin
        mat_q[k] <= mat_q[k-1];
      end
    end
    for (int k = 3; k <= 11; k++) begin
      if (en[k]) begin
        tq_q[k] <= tq_q[k-1];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/bfdw_chk.sv]
// ----------------------------------------------------------------------------
// bfdw_chk
// Port-level checks of the drag wrench pipeline: output hold, ready
// propagation, reset and fixed latency with a free-running sink.
// ----------------------------------------------------------------------------
`default_nettype none

module bfdw_chk (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       s_axis_tvalid,
  input wire logic                       s_axis_tready,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [bfdw_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int NS  = bfdw_pkg::STAGES;
  localparam int CW  = $clog2(NS + 1);

  logic [CW-1:0] rdy_cnt_q;
  logic          s_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdy_cnt_q <= '0;
    end else if (!m_axis_tready) begin
      rdy_cnt_q <= '0;
    end else if (rdy_cnt_q != CW'(NS)) begin
      rdy_cnt_q <= rdy_cnt_q + 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output request changed while stalled");

  a_sink_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready || !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with a free output side");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(s_acc, NS) && rdy_cnt_q == CW'(NS) |-> m_axis_tvalid)
    else $error("request missing after pipeline latency");

endmodule

bind body_frame_drag_wrench bfdw_chk u_bfdw_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
